FILE: rtl/core/bbat_pkg.sv
// ----------------------------------------------------------------------------
// bbat_pkg
// Shared types and constants for the box affine transform core.
// ----------------------------------------------------------------------------
package bbat_pkg;

  localparam int COEF_BITS = 21;
  localparam int CRD_BITS  = 32;
  localparam int EXT_BITS  = CRD_BITS + 1;     // corner coordinates, exact
  localparam int ROW_BITS  = 3 * COEF_BITS;    // 63

  // Register map, index = paddr / 8
  typedef enum logic [2:0] {
    REG_ROW_X   = 3'd0,
    REG_ROW_Y   = 3'd1,
    REG_ROW_Z   = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } reg_idx_t;

  // Box as low and high corner per axis
  typedef struct packed {
    logic [2:0][EXT_BITS-1:0] lo;
    logic [2:0][EXT_BITS-1:0] hi;
  } box_t;

  // Live configuration seen by the back end
  typedef struct packed {
    logic [2:0][ROW_BITS-1:0] rows;
    logic [2:0][CRD_BITS-1:0] shifts;
  } cfg_t;

endpackage

FILE: rtl/core/bbat_front.sv
// ----------------------------------------------------------------------------
// bbat_front
// Takes a box request and forms the low and high corner on each axis.
// ----------------------------------------------------------------------------
module bbat_front
  import bbat_pkg::*;
(
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [6*CRD_BITS-1:0] s_axis_tdata,  // center_x/y/z, half_x/y/z
  output logic                  push,
  output box_t                  push_box,
  input  logic                  q_full
);

  logic signed [EXT_BITS-1:0] ctr [3];
  logic signed [EXT_BITS-1:0] hlf [3];

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  // center +- half at 33 bits, no clipping
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      ctr[r] = EXT_BITS'($signed(s_axis_tdata[r*CRD_BITS +: CRD_BITS]));
      hlf[r] = EXT_BITS'($signed(s_axis_tdata[(r+3)*CRD_BITS +: CRD_BITS]));
      push_box.lo[r] = ctr[r] - hlf[r];
      push_box.hi[r] = ctr[r] + hlf[r];
    end
  end

endmodule

FILE: rtl/core/bbat_queue.sv
// ----------------------------------------------------------------------------
// bbat_queue
// Two-entry queue between front and back end.
// ----------------------------------------------------------------------------
module bbat_queue
  import bbat_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  box_t push_box,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output box_t head
);

  logic [1:0] count;
  box_t       slot1;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        head <= slot1;
        if (push) slot1 <= push_box;
      end else if (push) begin
        head <= push_box;
      end
    end else if (push) begin
      if (count == 2'd0) head <= push_box;
      else slot1 <= push_box;
    end
  end

endmodule

FILE: rtl/core/bbat_back.sv
// ----------------------------------------------------------------------------
// bbat_back
// Transform pipeline: per-axis extreme sums, floor/saturate, center and
// half-extent, squares and a pipelined integer square root.
// ----------------------------------------------------------------------------
module bbat_back
  import bbat_pkg::*;
#(
  parameter int FRAC_BITS = 16
)(
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  q_valid,
  input  box_t                  head,
  output logic                  pop,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7*CRD_BITS-1:0] m_axis_tdata
);

  localparam int NST      = 14;
  localparam int PRD_BITS = EXT_BITS + COEF_BITS;   // 54
  localparam int SUM_BITS = PRD_BITS + 2;           // 56
  localparam int SQ_STEPS = 4;                      // root bits per stage
  localparam int SQ_STG   = 32 / SQ_STEPS;          // 8
  localparam int REM_BITS = 34;

  logic [NST-1:0] v;
  logic           en;

  logic signed [PRD_BITS-1:0] plo [3][3];
  logic signed [PRD_BITS-1:0] phi [3][3];
  logic signed [SUM_BITS-1:0] smn [3];
  logic signed [SUM_BITS-1:0] smx [3];
  logic signed [CRD_BITS-1:0] mn  [3];
  logic signed [CRD_BITS-1:0] mx  [3];
  logic [2:0][CRD_BITS-1:0]   cen;
  logic [2:0][CRD_BITS-1:0]   hlf;
  logic [63:0]                sq  [3];
  logic [63:0]                sumsq;
  // center/half delay line, sits beside the squares stage, the sum stage and the root stages
  logic [6*CRD_BITS-1:0]      dl   [SQ_STG+2];
  logic [63:0]                sq_n [SQ_STG];
  logic [REM_BITS-1:0]        sq_r [SQ_STG];
  logic [31:0]                sq_q [SQ_STG];

  assign en            = m_axis_tready || !v[NST-1];
  assign pop           = en && q_valid;
  assign m_axis_tvalid = v[NST-1];
  assign m_axis_tdata  = {sq_q[SQ_STG-1], dl[SQ_STG+1]};

  // four restoring square-root steps
  function automatic logic [REM_BITS+64+32-1:0] sq_step(
    input logic [63:0] n_in, input logic [REM_BITS-1:0] r_in, input logic [31:0] q_in);
    logic [63:0]         n;
    logic [REM_BITS-1:0] r;
    logic [31:0]         q;
    logic [REM_BITS-1:0] trial;
    n = n_in; r = r_in; q = q_in;
    for (int i = 0; i < SQ_STEPS; i++) begin
      r     = {r[REM_BITS-3:0], n[63:62]};
      n     = {n[61:0], 2'b00};
      trial = {q, 2'b01};
      if (r >= trial) begin
        r = r - trial;
        q = {q[30:0], 1'b1};
      end else begin
        q = {q[30:0], 1'b0};
      end
    end
    return {n, r, q};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NST-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    logic signed [SUM_BITS:0] t;
    logic signed [EXT_BITS-1:0] a;
    logic signed [EXT_BITS-1:0] d;
    logic signed [COEF_BITS-1:0] k;
    if (en) begin
      // stage 0: products with both corners
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          k = $signed(cfg.rows[r][c*COEF_BITS +: COEF_BITS]);
          plo[r][c] <= $signed(head.lo[r]) * k;
          phi[r][c] <= $signed(head.hi[r]) * k;
        end
      end
      // stage 1: extreme over corners is per-term min/max, summed
      for (int c = 0; c < 3; c++) begin
        smn[c] <= SUM_BITS'((plo[0][c] < phi[0][c]) ? plo[0][c] : phi[0][c])
                + SUM_BITS'((plo[1][c] < phi[1][c]) ? plo[1][c] : phi[1][c])
                + SUM_BITS'((plo[2][c] < phi[2][c]) ? plo[2][c] : phi[2][c]);
        smx[c] <= SUM_BITS'((plo[0][c] < phi[0][c]) ? phi[0][c] : plo[0][c])
                + SUM_BITS'((plo[1][c] < phi[1][c]) ? phi[1][c] : plo[1][c])
                + SUM_BITS'((plo[2][c] < phi[2][c]) ? phi[2][c] : plo[2][c]);
      end
      // stage 2: floor, translate, saturate (monotonic, so extremes carry)
      for (int c = 0; c < 3; c++) begin
        t = (SUM_BITS+1)'(smn[c] >>> FRAC_BITS) + (SUM_BITS+1)'($signed(cfg.shifts[c]));
        mn[c] <= (t > 57'sd2147483647) ? 32'sh7fffffff :
                 (t < -57'sd2147483648) ? 32'sh80000000 : CRD_BITS'(t);
        t = (SUM_BITS+1)'(smx[c] >>> FRAC_BITS) + (SUM_BITS+1)'($signed(cfg.shifts[c]));
        mx[c] <= (t > 57'sd2147483647) ? 32'sh7fffffff :
                 (t < -57'sd2147483648) ? 32'sh80000000 : CRD_BITS'(t);
      end
      // stage 3: center and half-extent
      for (int c = 0; c < 3; c++) begin
        a = EXT_BITS'(mx[c]) + EXT_BITS'(mn[c]);
        d = EXT_BITS'(mx[c]) - EXT_BITS'(mn[c]);
        cen[c] <= a[EXT_BITS-1:1];
        hlf[c] <= {1'b0, d[CRD_BITS-1:1]};
      end
      // stage 4: squares; stage 5: sum
      for (int c = 0; c < 3; c++) sq[c] <= hlf[c] * hlf[c];
      sumsq <= sq[0] + sq[1] + sq[2];
      dl[0] <= {hlf, cen};
      for (int s = 1; s <= SQ_STG + 1; s++) dl[s] <= dl[s-1];
      // stages 6..13: square root, four bits per stage
      {sq_n[0], sq_r[0], sq_q[0]} <= sq_step(sumsq, '0, '0);
      for (int s = 1; s < SQ_STG; s++)
        {sq_n[s], sq_r[s], sq_q[s]} <= sq_step(sq_n[s-1], sq_r[s-1], sq_q[s-1]);
    end
  end

`ifndef SYNTHESIS
  a_minmax_order: assert property (@(posedge clk) disable iff (rst)
    v[2] |-> (mn[0] <= mx[0]) && (mn[1] <= mx[1]) && (mn[2] <= mx[2]))
    else $error("min above max");
  a_radius_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (sq_q[SQ_STG-1] >= dl[SQ_STG+1][3*CRD_BITS +: CRD_BITS]) &&
      (sq_q[SQ_STG-1] >= dl[SQ_STG+1][4*CRD_BITS +: CRD_BITS]) &&
      (sq_q[SQ_STG-1] >= dl[SQ_STG+1][5*CRD_BITS +: CRD_BITS]))
    else $error("radius below a half-extent");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (en && v[NST-2]) |=> m_axis_tvalid)
    else $error("result lost in pipeline");
`endif

endmodule

FILE: rtl/core/bounding_box_affine_transform_core.sv
// ----------------------------------------------------------------------------
// bounding_box_affine_transform_core
// Affine transform of a center/half-extent box with bounding-sphere radius.
// ----------------------------------------------------------------------------
// channel   | dir | width | contents
// s_axis    | in  | 192   | center_x/y/z, half_x/y/z (Q16.16, signed)
// m_axis    | out | 224   | new_center_x/y/z, new_half_x/y/z, bound_radius
// apb       | in  | 64    | matrix rows at 0x00/08/10, shifts at 0x18/20/28
//
// One box per cycle sustained while m_axis is ready; each box passes the
// queue head, six arithmetic stages and eight square-root stages
// (4 root bits per stage).
// Reset (rst, synchronous) clears queue and pipeline valids and loads the
// identity matrix and zero translation.
// A stalled m_axis freezes the back pipeline; the input side keeps taking
// requests until both slots of the 2-entry queue are occupied.
// ----------------------------------------------------------------------------
module bounding_box_affine_transform_core
  import bbat_pkg::*;
#(
  parameter int FRAC_BITS = 16
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [6*CRD_BITS-1:0] s_axis_tdata,   // center_x, center_y, center_z,
                                                // half_x, half_y, half_z
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7*CRD_BITS-1:0] m_axis_tdata,   // new_center_x/y/z,
                                                // new_half_x/y/z, bound_radius
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [5:0]            paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  cfg_t cfg;
  logic push, q_full, q_valid, pop, wr;
  box_t push_box, head;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows[0]   <= ROW_BITS'(64'd1 << FRAC_BITS);
      cfg.rows[1]   <= ROW_BITS'(64'd1 << (FRAC_BITS + COEF_BITS));
      cfg.rows[2]   <= ROW_BITS'(64'd1 << (FRAC_BITS + 2*COEF_BITS));
      cfg.shifts    <= '0;
    end else if (wr) begin
      case (reg_idx_t'(paddr[5:3]))
        REG_ROW_X:   cfg.rows[0]   <= pwdata[ROW_BITS-1:0];
        REG_ROW_Y:   cfg.rows[1]   <= pwdata[ROW_BITS-1:0];
        REG_ROW_Z:   cfg.rows[2]   <= pwdata[ROW_BITS-1:0];
        REG_SHIFT_X: cfg.shifts[0] <= pwdata[CRD_BITS-1:0];
        REG_SHIFT_Y: cfg.shifts[1] <= pwdata[CRD_BITS-1:0];
        REG_SHIFT_Z: cfg.shifts[2] <= pwdata[CRD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[5:3]))
      REG_ROW_X:   prdata = {1'b0, cfg.rows[0]};
      REG_ROW_Y:   prdata = {1'b0, cfg.rows[1]};
      REG_ROW_Z:   prdata = {1'b0, cfg.rows[2]};
      REG_SHIFT_X: prdata = {32'd0, cfg.shifts[0]};
      REG_SHIFT_Y: prdata = {32'd0, cfg.shifts[1]};
      REG_SHIFT_Z: prdata = {32'd0, cfg.shifts[2]};
      default:     prdata = '0;
    endcase
  end

  bbat_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push          (push),
    .push_box      (push_box),
    .q_full        (q_full)
  );

  bbat_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_box (push_box),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  bbat_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
